// ===== rtl/spa_pkg.sv =====
package spa_pkg;

   localparam int SAMPLE_W = 16;
   localparam int ENTRY_W  = 2 * SAMPLE_W;
   localparam int MARGIN   = 16;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_INITIAL_PRESSURE   = 1'b0,
      CSR_MOVEMENT_THRESHOLD = 1'b1
   } csr_idx_type;

   typedef enum logic {
      ACT_STORE = 1'b0,
      ACT_CHECK = 1'b1
   } action_type;

   // Item in the update stage, which takes the data of the memory read issued when the item was accepted.
   typedef struct packed {
      logic                valid;
      logic                store;
      logic [SAMPLE_W-1:0] pressure;
      logic                entry_valid; // leaving entry was written since reset
      logic                fwd;         // leaving entry is the one just written
   } s1_ctl_type;

endpackage

// ===== rtl/spa_mem.sv =====
module spa_mem import spa_pkg::*; #(
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [ENTRY_W-1:0]       wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [ENTRY_W-1:0]       rd_data
);

   logic [ENTRY_W-1:0] mem [DEPTH];
   logic [ENTRY_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/spa_window.sv =====
module spa_window import spa_pkg::*; #(
   parameter int WEFF  = 32,
   parameter int SUM_W = 21
) (
   input  logic                  clock,
   input  logic                  reset,
   input  s1_ctl_type            s1,
   input  logic                  s1_adv,
   input  logic [ENTRY_W-1:0]    rd_data,
   input  logic [SAMPLE_W-1:0]   init_pressure,
   input  logic [SAMPLE_W-1:0]   move_thresh,
   output logic                  wr_en,
   output logic [ENTRY_W-1:0]    wr_data,
   output logic                  alarm
);

   localparam int MUL_W = SAMPLE_W + 1 + $clog2(WEFF + 1);

   logic [SUM_W-1:0]    psum_ff, psum_in;
   logic [SUM_W-1:0]    msum_ff, msum_in;
   logic [SAMPLE_W-1:0] prev_ff;
   logic [ENTRY_W-1:0]  last_wr_ff;
   logic [ENTRY_W-1:0]  leave;
   logic [SAMPLE_W-1:0] leave_p, leave_m, move;
   logic [MUL_W-1:0]    move_lim, press_lim;
   logic                still, raised, filled;

   // leaving entry: forwarded from the write of the previous item if it hit
   assign leave   = s1.fwd ? last_wr_ff : rd_data;
   assign leave_p = s1.entry_valid ? leave[ENTRY_W-1:SAMPLE_W] : '0;
   assign leave_m = s1.entry_valid ? leave[SAMPLE_W-1:0] : '0;

   assign move = (s1.pressure >= prev_ff) ? (s1.pressure - prev_ff)
                                          : (prev_ff - s1.pressure);

   assign wr_en   = s1.valid && s1.store && s1_adv;
   assign wr_data = {s1.pressure, move};

   assign psum_in = psum_ff - SUM_W'(leave_p) + SUM_W'(s1.pressure);
   assign msum_in = msum_ff - SUM_W'(leave_m) + SUM_W'(move);

   always_ff @(posedge clock) begin
      if (reset) begin
         psum_ff <= '0;
         msum_ff <= '0;
         prev_ff <= '0;
      end else if (wr_en) begin
         psum_ff <= psum_in;
         msum_ff <= msum_in;
         prev_ff <= s1.pressure;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         last_wr_ff <= wr_data;
      end
   end

   // averages compared as sums against thresholds scaled by the window size
   assign move_lim  = MUL_W'(move_thresh) * MUL_W'(WEFF);
   assign press_lim = (MUL_W'(init_pressure) + MUL_W'(MARGIN)) * MUL_W'(WEFF);

   assign still  = MUL_W'(msum_ff) < move_lim;
   assign raised = MUL_W'(psum_ff) > press_lim;
   assign filled = leave_p != '0;
   assign alarm  = still && raised && filled;

endmodule

// ===== rtl/stillness_pressure_alarm.sv =====
// Stillness-under-pressure alarm. Store transactions (req_action = 0) push a
// pressure sample and its absolute change from the previous sample into a
// circular memory of BUFFER_DEPTH entries and keep running sums over the
// newest min(WINDOW, BUFFER_DEPTH) samples; check transactions (req_action = 1)
// return one rsp_alarm, high when the movement sum is below
// movement_threshold times the window, the pressure sum is above
// (initial_pressure + 16) times the window, and the oldest window sample is
// nonzero. Inside, a transaction first reads the entry leaving the window
// from the single-port-read memory, then updates the sums and writes the
// new entry. Successive transactions overlap, so one transaction per
// cycle is sustained; a check stalls the input only when the result register
// still holds an untaken result. The memory needs no clearing pass after
// reset: entries are written in order, so an entry counts as zero until the
// write pointer has passed it once. Write csr_* only while no transaction is
// in flight.
module stillness_pressure_alarm import spa_pkg::*; #(
   parameter int BUFFER_DEPTH = 64,
   parameter int WINDOW       = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_action,
   input  logic [SAMPLE_W-1:0]   req_pressure,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_alarm,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);

   localparam int WEFF     = (WINDOW < BUFFER_DEPTH) ? WINDOW : BUFFER_DEPTH;
   localparam int PTR_W    = $clog2(BUFFER_DEPTH);
   localparam int SUM_W    = SAMPLE_W + $clog2(WEFF);
   localparam int TAIL_RST = (BUFFER_DEPTH - WEFF) % BUFFER_DEPTH;
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(BUFFER_DEPTH - 1);

   // configuration
   logic [SAMPLE_W-1:0] init_p_ff, move_thr_ff;

   // pointers advance when a store is accepted
   logic [PTR_W-1:0] wp_ff, wp_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic             wrapped_ff, wrapped_in;

   // update stage
   s1_ctl_type       s1_ff, s1_in;
   logic [PTR_W-1:0] s1_waddr_ff;
   logic             s1_adv;

   // result register
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_alarm_ff;

   logic                accept, accept_store;
   logic                wr_en;
   logic [ENTRY_W-1:0]  wr_data, rd_data;
   logic                alarm;

   always_ff @(posedge clock) begin
      if (reset) begin
         init_p_ff   <= '0;
         move_thr_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_idx_type'(csr_index))
            CSR_INITIAL_PRESSURE:   init_p_ff   <= csr_wr_data[SAMPLE_W-1:0];
            CSR_MOVEMENT_THRESHOLD: move_thr_ff <= csr_wr_data[SAMPLE_W-1:0];
            default: ;
         endcase
      end
   end

   // a check in the update stage waits for room in the result register
   assign s1_adv = !(s1_ff.valid && !s1_ff.store && rsp_valid_ff && !rsp_ready);
   assign req_ready    = !s1_ff.valid || s1_adv;
   assign accept       = req_valid && req_ready;
   assign accept_store = accept && (req_action == ACT_STORE);

   always_comb begin
      wp_in      = wp_ff;
      tail_in    = tail_ff;
      wrapped_in = wrapped_ff;
      if (accept_store) begin
         wp_in   = (wp_ff == PTR_LAST) ? '0 : wp_ff + 1'b1;
         tail_in = (tail_ff == PTR_LAST) ? '0 : tail_ff + 1'b1;
         if (wp_ff == PTR_LAST) begin
            wrapped_in = 1'b1;
         end
      end
   end

   always_comb begin
      s1_in = s1_ff;
      if (accept) begin
         s1_in.valid       = 1'b1;
         s1_in.store       = (req_action == ACT_STORE);
         s1_in.pressure    = req_pressure;
         s1_in.entry_valid = wrapped_ff || (tail_ff < wp_ff);
         // previous store writes the very entry being read this cycle
         s1_in.fwd         = s1_ff.valid && s1_ff.store && (s1_waddr_ff == tail_ff);
      end else if (s1_adv) begin
         s1_in.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff      <= '0;
         tail_ff    <= PTR_W'(TAIL_RST);
         wrapped_ff <= 1'b0;
         s1_ff      <= '0;
      end else begin
         wp_ff      <= wp_in;
         tail_ff    <= tail_in;
         wrapped_ff <= wrapped_in;
         s1_ff      <= s1_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_waddr_ff <= wp_ff;
      end
   end

   spa_mem #(
      .DEPTH (BUFFER_DEPTH)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s1_waddr_ff),
      .wr_data (wr_data),
      .rd_en   (accept),
      .rd_addr (tail_ff),
      .rd_data (rd_data)
   );

   spa_window #(
      .WEFF  (WEFF),
      .SUM_W (SUM_W)
   ) u_window (
      .clock         (clock),
      .reset         (reset),
      .s1            (s1_ff),
      .s1_adv        (s1_adv),
      .rd_data       (rd_data),
      .init_pressure (init_p_ff),
      .move_thresh   (move_thr_ff),
      .wr_en         (wr_en),
      .wr_data       (wr_data),
      .alarm         (alarm)
   );

   // result register: loads when a check leaves the update stage
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_ff.valid && !s1_ff.store && s1_adv) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ff.valid && !s1_ff.store && s1_adv) begin
         rsp_alarm_ff <= alarm;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_alarm = rsp_alarm_ff;

   // a result appears only after a check occupied the update stage
   a_rsp_from_check: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_ff.valid && !s1_ff.store))
      else $error("result without a check transaction");

   // a stalled update stage holds its item
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_ff.valid && !s1_adv) |=> $stable(s1_ff))
      else $error("update stage changed while stalled");

   // every accepted store moves the write pointer
   a_wp_moves: assert property (@(posedge clock) disable iff (reset)
      accept_store |=> (wp_ff != $past(wp_ff)))
      else $error("write pointer did not advance on store");

endmodule

// ===== test/spa_alarm_checker.sv =====
module spa_alarm_checker import spa_pkg::*; #(
   parameter int BUFFER_DEPTH = 64,
   parameter int WINDOW       = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic                  req_action,
   input  logic [SAMPLE_W-1:0]   req_pressure,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic                  rsp_alarm,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data,
   output int                    errors,
   output int                    outstanding
);

   // window clamps to the store size
   localparam int SPAN = (WINDOW < BUFFER_DEPTH) ? WINDOW : BUFFER_DEPTH;

   logic [SAMPLE_W-1:0] base_pressure;
   logic [SAMPLE_W-1:0] still_limit;
   logic [SAMPLE_W-1:0] level_hist [BUFFER_DEPTH];
   logic [SAMPLE_W-1:0] change_hist [BUFFER_DEPTH];
   logic [SAMPLE_W-1:0] last_level;
   int unsigned         head;
   longint unsigned     level_sum;
   longint unsigned     change_sum;
   logic                pending_alarms [$];
   int                  results_seen;

   function automatic int unsigned oldest_slot();
      return (head + BUFFER_DEPTH - SPAN) % BUFFER_DEPTH;
   endfunction

   task automatic push_sample(input logic [SAMPLE_W-1:0] level);
      int unsigned         tail;
      logic [SAMPLE_W-1:0] change;
      tail   = oldest_slot();
      change = (level >= last_level) ? level - last_level : last_level - level;
      level_sum  = level_sum - level_hist[tail] + level;
      change_sum = change_sum - change_hist[tail] + change;
      level_hist[head]  = level;
      change_hist[head] = change;
      last_level = level;
      head = (head + 1) % BUFFER_DEPTH;
   endtask

   function automatic logic window_alarm();
      longint unsigned span;
      logic            still;
      logic            raised;
      logic            filled;
      span   = SPAN;
      still  = change_sum < 64'(still_limit) * span;
      raised = level_sum > (64'(base_pressure) + 64'(MARGIN)) * span;
      filled = level_hist[oldest_slot()] != '0;
      return still && raised && filled;
   endfunction

   task automatic report_mismatch(input string what);
      errors++;
      $display("%0t: alarm result %0d: %s", $time, results_seen, what);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         base_pressure = '0;
         still_limit   = '0;
         last_level    = '0;
         head          = 0;
         level_sum     = 0;
         change_sum    = 0;
         results_seen  = 0;
         errors        = 0;
         foreach (level_hist[k]) begin
            level_hist[k]  = '0;
            change_hist[k] = '0;
         end
         pending_alarms.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_idx_type'(csr_index))
               CSR_INITIAL_PRESSURE:   base_pressure = csr_wr_data;
               CSR_MOVEMENT_THRESHOLD: still_limit   = csr_wr_data;
               default: ;
            endcase
         end
         // a result never belongs to a check taken at the same edge
         if (rsp_valid && rsp_ready) begin
            if (pending_alarms.size() == 0) begin
               report_mismatch("result with no check waiting");
            end else if (rsp_alarm !== pending_alarms[0]) begin
               report_mismatch($sformatf("alarm %b, expected %b", rsp_alarm,
                                         pending_alarms[0]));
               void'(pending_alarms.pop_front());
            end else begin
               void'(pending_alarms.pop_front());
            end
            results_seen++;
         end
         if (req_valid && req_ready) begin
            if (req_action == ACT_STORE) begin
               push_sample(req_pressure);
            end else begin
               pending_alarms.push_back(window_alarm());
            end
         end
      end
      outstanding = pending_alarms.size();
   end

endmodule

// ===== test/tb.sv =====
module tb;
   import spa_pkg::*;

   localparam int DEPTH       = 64;
   localparam int WIN         = 32;
   localparam int PHASE_ITEMS = 210;
   localparam int HOLD_CYCLES = 400;   // long receiver hold-off
   localparam int QUIET_LIMIT = 5000;  // cycles with no transaction at all
   localparam int DRAIN_WAIT  = 4;     // lets the last store leave the pipeline

   typedef enum {RX_FREE, RX_RANDOM, RX_PATTERN} rx_mode_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic                  req_action = ACT_STORE;
   logic [SAMPLE_W-1:0]   req_pressure = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic                  rsp_alarm;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_INITIAL_PRESSURE;
   logic [CSR_DATA_W-1:0] csr_wr_data = '0;

   int          mismatch_count;
   int          alarms_due;
   int          burst_left = 0;
   int          quiet_cycles = 0;
   int          hold_asked = 0;
   int          hold_served = 0;
   int          hold_left = 0;
   int          rx_left = 0;
   int          rx_tick = 0;
   rx_mode_type rx_mode = RX_FREE;

   always #10 clock = ~clock;

   stillness_pressure_alarm #(
      .BUFFER_DEPTH(DEPTH),
      .WINDOW      (WIN)
   ) DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_action  (req_action),
      .req_pressure(req_pressure),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_alarm   (rsp_alarm),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   // Scoreboard: mirrors the window sums, predicts each check and compares.
   spa_alarm_checker #(
      .BUFFER_DEPTH(DEPTH),
      .WINDOW      (WIN)
   ) alarm_check (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_action  (req_action),
      .req_pressure(req_pressure),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_alarm   (rsp_alarm),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .errors      (mismatch_count),
      .outstanding (alarms_due)
   );

   // Offer one transaction and hold it until taken. Bursts of random length
   // with random gaps between them; some bursts are long enough to stream.
   task automatic offer(input action_type act, input logic [SAMPLE_W-1:0] level);
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 150)
                                                  : $urandom_range(1, 25);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid    <= 1'b1;
      req_action   <= act;
      req_pressure <= level;
      do @(posedge clock); while (!req_ready);
   endtask

   // Stop sending and wait for every pending alarm, then let the last store
   // (which returns nothing) work its way out of the pipeline.
   task automatic settle();
      req_valid <= 1'b0;
      @(negedge clock);
      while (alarms_due != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_config(input logic [CSR_DATA_W-1:0] base,
                               input logic [CSR_DATA_W-1:0] limit);
      csr_wr_en   <= 1'b1;
      csr_index   <= CSR_INITIAL_PRESSURE;
      csr_wr_data <= base;
      @(posedge clock);
      csr_index   <= CSR_MOVEMENT_THRESHOLD;
      csr_wr_data <= limit;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // One configuration phase. Mostly steady segments: samples hover around
   // the raised-pressure line with jitter near the stillness limit, so both
   // comparisons land close to their edges. About one segment in five is
   // noise (any action, any pressure).
   task automatic run_phase(input int base, input int limit, input int count,
                            input int hold_at);
      int   sent;
      int   seg_left;
      int   level;
      int   jitter;
      int   v;
      logic noisy;
      sent     = 0;
      seg_left = 0;
      level    = 0;
      jitter   = 0;
      noisy    = 1'b0;
      settle();
      write_config(base[CSR_DATA_W-1:0], limit[CSR_DATA_W-1:0]);
      while (sent < count) begin
         if (seg_left == 0) begin
            seg_left = $urandom_range(20, 70);
            noisy    = ($urandom_range(0, 4) == 0);
            level    = base + MARGIN + int'($urandom_range(0, 8)) - 3;
            if (level > 65535) level = 65535;
            jitter   = $urandom_range(0, ((limit < 2000) ? limit : 2000) + 2);
         end
         if (sent == hold_at) hold_asked <= hold_asked + 1;
         if (noisy) begin
            offer(action_type'($urandom_range(0, 1)), SAMPLE_W'($urandom));
         end else if ($urandom_range(0, 3) == 0) begin
            // pressure on a check is don't-care; randomize it anyway
            offer(ACT_CHECK, SAMPLE_W'($urandom));
         end else begin
            v = level + int'($urandom_range(0, 2 * jitter)) - jitter;
            if (v < 0) v = 0;
            if (v > 65535) v = 65535;
            offer(ACT_STORE, SAMPLE_W'(v));
         end
         sent++;
         seg_left--;
      end
   endtask

   // Receiver: free-running, random stalls or a fixed duty pattern, changing
   // mode at random intervals. A hold-off request blocks it outright.
   initial begin
      forever begin
         @(posedge clock);
         rx_tick++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (hold_served != hold_asked) begin
            hold_served = hold_asked;
            hold_left   = HOLD_CYCLES - 1;
            rsp_ready  <= 1'b0;
         end else begin
            if (rx_left == 0) begin
               rx_mode = rx_mode_type'($urandom_range(0, 2));
               rx_left = $urandom_range(10, 80);
            end
            rx_left--;
            case (rx_mode)
               RX_FREE:   rsp_ready <= 1'b1;
               RX_RANDOM: rsp_ready <= ($urandom_range(0, 2) != 0);
               default:   rsp_ready <= ((rx_tick % 5) < 2);
            endcase
         end
      end
   end

   // Watchdog: any transaction on any port restarts the count.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_wr_en) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int base;
      int limit;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: check on an empty store, full-scale first sample (its
      // movement is the sample itself), rail-to-rail swings, then a partly
      // filled window that must not alarm since the oldest entry is zero.
      write_config('0, '1);
      offer(ACT_CHECK, '1);
      offer(ACT_STORE, '1);
      offer(ACT_CHECK, '0);
      offer(ACT_STORE, '0);
      offer(ACT_STORE, '1);
      offer(ACT_CHECK, '1);
      repeat (14) offer(ACT_STORE, SAMPLE_W'(1000 + $urandom_range(0, 3)));
      offer(ACT_CHECK, '0);

      // Register extremes first: zero limit never counts as still, a full
      // scale baseline can never be exceeded.
      run_phase(0, 0, PHASE_ITEMS, -1);
      run_phase(65535, 65535, PHASE_ITEMS, -1);
      // long receiver hold-off while the sender keeps pushing
      run_phase($urandom_range(0, 65535), $urandom_range(1, 64), PHASE_ITEMS, 60);
      repeat (5) begin
         base = $urandom_range(0, 65535);
         case ($urandom_range(0, 2))
            0:       limit = $urandom_range(1, 64);
            1:       limit = $urandom_range(64, 1500);
            default: limit = 65535;
         endcase
         run_phase(base, limit, PHASE_ITEMS, -1);
      end

      settle();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && alarms_due == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
